// ===== hdl/a2l_pkg.sv =====
// Shared types, constants and codes of the Annex B to length-prefixed NAL converter.
`default_nettype none
package a2l_pkg;
    localparam int ADDR_W = 16;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int MARK_W = ADDR_W + 2;
    localparam int LEN_W  = 32;

    localparam logic [CNT_W-1:0] MAX_UNIT_BYTES = CNT_W'(65536);
    localparam logic [2:0]       LENGTH_BYTES   = 3'd4;

    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    localparam logic [1:0] ACT_LEAVE = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    localparam logic [1:0] CFG_SINGLE_NAL = 2'd0;
    localparam logic [1:0] CFG_PPS_OFFSET = 2'd1;
    localparam logic [1:0] CFG_PSETS_END  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic             done;
        logic             keep;
        logic [CNT_W-1:0] start;
        logic [1:0]       action;
    } conv_res_t;
endpackage
`default_nettype wire

// ===== hdl/a2l_ram.sv =====
// Single-port synchronous RAM with registered read data.
`default_nettype none
module a2l_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== hdl/a2l_conv.sv =====
// Conversion sequencer: scans the stored unit for start codes and writes NAL lengths.
`default_nettype none
module a2l_conv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [a2l_pkg::CNT_W-1:0]   unit_len,
    input  wire logic                        single_mode,
    input  wire logic [15:0]                 pps_offset,
    input  wire logic [15:0]                 param_sets_end,
    input  wire logic [7:0]                  rdata,
    output a2l_pkg::mem_req_t                mem_req,
    output a2l_pkg::conv_res_t               res
);
    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_RD   = 3'd1;
    localparam logic [2:0] C_EV   = 3'd2;
    localparam logic [2:0] C_T2RD = 3'd3;
    localparam logic [2:0] C_DEC  = 3'd4;
    localparam logic [2:0] C_TAIL = 3'd5;
    localparam logic [2:0] C_WR   = 3'd6;
    localparam logic [2:0] C_FIN  = 3'd7;

    logic [2:0] state_reg, state_next, ret_reg, ret_next;
    logic [a2l_pkg::CNT_W-1:0] n_reg, n_next, j_reg, j_next, start_reg, start_next;
    logic [31:0] win_reg, win_next;
    logic have_reg, have_next;
    logic [4:0] type_reg, type_next, t1_reg, t1_next;
    logic [a2l_pkg::MARK_W-1:0] mark_reg, mark_next, wr_mark_reg, wr_mark_next;
    logic [1:0] action_reg, action_next, k_reg, k_next;
    logic [a2l_pkg::ADDR_W-1:0] i_reg, i_next;
    logic t2_in_reg, t2_in_next;
    logic [a2l_pkg::LEN_W-1:0] wr_len_reg, wr_len_next;

    logic sc;
    logic [a2l_pkg::CNT_W-1:0] i_wide, j_inc, pps_addr, start_dec;
    logic [2:0] scan_next;
    logic [4:0] typ, t2;
    logic [a2l_pkg::MARK_W:0] diff_i, diff_tail;
    logic [a2l_pkg::MARK_W-1:0] mark_m, k_plus;
    logic wr_ok;

    assign sc        = (j_reg >= a2l_pkg::CNT_W'(4)) && (win_reg == 32'h0000_0001);
    assign i_wide    = j_reg - a2l_pkg::CNT_W'(4);
    assign typ       = rdata[4:0];
    assign j_inc     = j_reg + a2l_pkg::CNT_W'(1);
    assign scan_next = (j_inc < n_reg) ? C_RD : C_TAIL;
    assign pps_addr  = {1'b0, i_reg} + {1'b0, pps_offset};
    assign start_dec = {1'b0, i_reg} + {1'b0, param_sets_end};
    assign t2        = t2_in_reg ? rdata[4:0] : 5'd0;
    assign diff_i    = {2'b00, i_wide} - {1'b0, mark_reg};
    assign diff_tail = {2'b00, n_reg} - {1'b0, mark_reg};
    assign k_plus    = a2l_pkg::MARK_W'(k_reg) + a2l_pkg::MARK_W'(1);
    assign mark_m    = wr_mark_reg - k_plus;
    assign wr_ok     = (wr_mark_reg >= k_plus) && (mark_m < {1'b0, n_reg});

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        start_next  = start_reg;
        win_next    = win_reg;
        have_next   = have_reg;
        type_next   = type_reg;
        t1_next     = t1_reg;
        mark_next   = mark_reg;
        wr_mark_next = wr_mark_reg;
        action_next = action_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        t2_in_next  = t2_in_reg;
        wr_len_next = wr_len_reg;
        mem_req.we    = 1'b0;
        mem_req.addr  = j_reg[a2l_pkg::ADDR_W-1:0];
        mem_req.wdata = 8'd0;
        res.done   = 1'b0;
        res.keep   = start_reg < n_reg;
        res.start  = start_reg;
        res.action = action_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (go)
                begin
                    n_next      = unit_len;
                    j_next      = '0;
                    have_next   = 1'b0;
                    start_next  = '0;
                    action_next = a2l_pkg::ACT_LEAVE;
                    type_next   = 5'd0;
                    mark_next   = '0;
                    state_next  = C_RD;
                end
            end
            C_RD:
            begin
                state_next = C_EV;
            end
            C_EV:
            begin
                win_next   = {win_reg[23:0], rdata};
                j_next     = j_inc;
                state_next = scan_next;
                if (sc)
                begin
                    if (single_mode)
                    begin
                        i_next     = i_wide[a2l_pkg::ADDR_W-1:0];
                        t1_next    = typ;
                        state_next = C_T2RD;
                    end
                    else
                    begin
                        if (have_reg)
                        begin
                            if (type_reg == a2l_pkg::NAL_SPS || type_reg == a2l_pkg::NAL_PPS)
                            begin
                                start_next = i_wide;
                            end
                            else
                            begin
                                wr_mark_next = mark_reg;
                                wr_len_next  = {{(a2l_pkg::LEN_W-a2l_pkg::MARK_W-1)
                                                 {diff_i[a2l_pkg::MARK_W]}}, diff_i};
                                k_next       = 2'd0;
                                ret_next     = scan_next;
                                state_next   = C_WR;
                            end
                        end
                        mark_next = {1'b0, i_wide} + a2l_pkg::MARK_W'(a2l_pkg::LENGTH_BYTES);
                        type_next = typ;
                        have_next = 1'b1;
                    end
                end
            end
            C_T2RD:
            begin
                mem_req.addr = pps_addr[a2l_pkg::ADDR_W-1:0];
                t2_in_next   = pps_addr < n_reg;
                state_next   = C_DEC;
            end
            C_DEC:
            begin
                // An SPS at the first start code with a PPS at its offset marks an I-frame.
                if (t1_reg == a2l_pkg::NAL_SPS && t2 == a2l_pkg::NAL_PPS)
                begin
                    start_next  = start_dec;
                    mark_next   = {1'b0, start_dec} + a2l_pkg::MARK_W'(a2l_pkg::LENGTH_BYTES);
                    action_next = a2l_pkg::ACT_CLEAR;
                end
                else
                begin
                    mark_next   = {2'b00, i_reg} + a2l_pkg::MARK_W'(a2l_pkg::LENGTH_BYTES);
                    action_next = a2l_pkg::ACT_SET;
                end
                have_next  = 1'b1;
                state_next = C_TAIL;
            end
            C_TAIL:
            begin
                if (have_reg)
                begin
                    wr_mark_next = mark_reg;
                    wr_len_next  = {{(a2l_pkg::LEN_W-a2l_pkg::MARK_W-1)
                                     {diff_tail[a2l_pkg::MARK_W]}}, diff_tail};
                    k_next       = 2'd0;
                    ret_next     = C_FIN;
                    state_next   = C_WR;
                end
                else
                begin
                    state_next = C_FIN;
                end
            end
            C_WR:
            begin
                // Least significant byte lands just before the mark.
                mem_req.we    = wr_ok;
                mem_req.addr  = mark_m[a2l_pkg::ADDR_W-1:0];
                mem_req.wdata = wr_len_reg[{k_reg, 3'b000} +: 8];
                k_next        = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ret_reg;
                end
            end
            C_FIN:
            begin
                res.done   = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg     <= ret_next;
        n_reg       <= n_next;
        j_reg       <= j_next;
        start_reg   <= start_next;
        win_reg     <= win_next;
        have_reg    <= have_next;
        type_reg    <= type_next;
        t1_reg      <= t1_next;
        mark_reg    <= mark_next;
        wr_mark_reg <= wr_mark_next;
        action_reg  <= action_next;
        k_reg       <= k_next;
        i_reg       <= i_next;
        t2_in_reg   <= t2_in_next;
        wr_len_reg  <= wr_len_next;
    end
endmodule
`default_nettype wire

// ===== hdl/annexb_to_length_prefixed_nal.sv =====
// Top level of the Annex B to length-prefixed NAL converter.
// Requests enter on start while busy is low; req_type selects a push of data_byte
// or a pull of one converted byte. Every request gives exactly one result beat,
// marked by done for one cycle; the receiver cannot stall it.
// A push without end_of_unit, a rejected push and an empty pull answer in the cycle
// after acceptance. A pull that returns data answers through the pull state, which
// captures the registered read of the unit memory into the result registers.
// A push with end_of_unit converts the unit in place. The sequencer reads the stored
// bytes one by one, each read followed by an evaluation state, and writes each length
// field a byte at a time. Multi-NAL mode scans the whole unit. Single-NAL mode stops
// at the first start code and reads the PPS header byte at the configured offset
// there.
// Busy is high only while a pull read or a conversion is under way, so a new request
// waits until the previous one has been handled.
// Configuration is written through cfg_valid/cfg_ready (always ready), index 0 to 2.
// Reset clears the fill count, read pointer and delta mark; the unit memory has no
// reset, and bytes beyond what has been written are never used.
`default_nettype none
module annexb_to_length_prefixed_nal (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_unit,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             out_last,
    output logic [1:0]       delta_action,
    output logic             overflow
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PULL = 2'd1;
    localparam logic [1:0] ST_CONV = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [a2l_pkg::CNT_W-1:0] fill_reg, fill_next, rp_reg, rp_next, rp_inc;
    logic ready_reg, ready_next;
    logic [1:0] delta_reg, delta_next;
    logic ovf_hold_reg, ovf_hold_next;
    logic single_nal_mode_reg;
    logic [15:0] pps_offset_reg, param_sets_end_reg;
    logic done_reg, done_next, valid_reg, valid_next, last_reg, last_next;
    logic ovf_reg, ovf_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] dact_reg, dact_next;

    logic accept, has_room, conv_go;
    logic [7:0] rdata;
    a2l_pkg::mem_req_t top_req, conv_req, mem_req;
    a2l_pkg::conv_res_t conv_res;

    assign busy      = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign has_room  = fill_reg < a2l_pkg::MAX_UNIT_BYTES;
    assign rp_inc    = rp_reg + a2l_pkg::CNT_W'(1);
    assign conv_go   = accept && req_type == a2l_pkg::REQ_PUSH && !ready_reg && end_of_unit;

    always_comb
    begin
        top_req.we    = accept && req_type == a2l_pkg::REQ_PUSH && !ready_reg && has_room;
        top_req.addr  = (req_type == a2l_pkg::REQ_PUSH) ? fill_reg[a2l_pkg::ADDR_W-1:0]
                                                          : rp_reg[a2l_pkg::ADDR_W-1:0];
        top_req.wdata = data_byte;
        mem_req       = (state_reg == ST_CONV) ? conv_req : top_req;
    end

    a2l_ram #(
        .ADDR_W (a2l_pkg::ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    a2l_conv u_conv (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (conv_go),
        .unit_len       (fill_next),
        .single_mode    (single_nal_mode_reg),
        .pps_offset     (pps_offset_reg),
        .param_sets_end (param_sets_end_reg),
        .rdata          (rdata),
        .mem_req        (conv_req),
        .res            (conv_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rp_next       = rp_reg;
        ready_next    = ready_reg;
        delta_next    = delta_reg;
        ovf_hold_next = ovf_hold_reg;
        done_next     = 1'b0;
        valid_next    = 1'b0;
        last_next     = 1'b0;
        ovf_next      = 1'b0;
        byte_next     = 8'd0;
        dact_next     = a2l_pkg::ACT_LEAVE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == a2l_pkg::REQ_PUSH)
                    begin
                        if (ready_reg)
                        begin
                            done_next = 1'b1;
                            ovf_next  = 1'b1;
                        end
                        else
                        begin
                            if (has_room)
                            begin
                                fill_next = fill_reg + a2l_pkg::CNT_W'(1);
                            end
                            if (end_of_unit)
                            begin
                                ovf_hold_next = !has_room;
                                state_next    = ST_CONV;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                ovf_next  = !has_room;
                            end
                        end
                    end
                    else if (ready_reg && rp_reg < fill_reg)
                    begin
                        state_next = ST_PULL;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_PULL:
            begin
                done_next  = 1'b1;
                valid_next = 1'b1;
                byte_next  = rdata;
                dact_next  = delta_reg;
                rp_next    = rp_inc;
                if (rp_inc >= fill_reg)
                begin
                    last_next  = 1'b1;
                    fill_next  = '0;
                    rp_next    = '0;
                    ready_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            ST_CONV:
            begin
                if (conv_res.done)
                begin
                    done_next  = 1'b1;
                    dact_next  = conv_res.action;
                    delta_next = conv_res.action;
                    ovf_next   = ovf_hold_reg;
                    if (conv_res.keep)
                    begin
                        rp_next    = conv_res.start;
                        ready_next = 1'b1;
                    end
                    else
                    begin
                        // Nothing is left to read out, so the unit is dropped at once.
                        fill_next  = '0;
                        rp_next    = '0;
                        ready_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            fill_reg            <= '0;
            rp_reg              <= '0;
            ready_reg           <= 1'b0;
            delta_reg           <= a2l_pkg::ACT_LEAVE;
            ovf_hold_reg        <= 1'b0;
            done_reg            <= 1'b0;
            valid_reg           <= 1'b0;
            last_reg            <= 1'b0;
            ovf_reg             <= 1'b0;
            byte_reg            <= 8'd0;
            dact_reg            <= a2l_pkg::ACT_LEAVE;
            single_nal_mode_reg <= 1'b0;
            pps_offset_reg      <= 16'd0;
            param_sets_end_reg  <= 16'd0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rp_reg       <= rp_next;
            ready_reg    <= ready_next;
            delta_reg    <= delta_next;
            ovf_hold_reg <= ovf_hold_next;
            done_reg     <= done_next;
            valid_reg    <= valid_next;
            last_reg     <= last_next;
            ovf_reg      <= ovf_next;
            byte_reg     <= byte_next;
            dact_reg     <= dact_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    a2l_pkg::CFG_SINGLE_NAL: single_nal_mode_reg <= cfg_data[0];
                    a2l_pkg::CFG_PPS_OFFSET: pps_offset_reg      <= cfg_data;
                    a2l_pkg::CFG_PSETS_END:  param_sets_end_reg  <= cfg_data;
                    default:                 single_nal_mode_reg <= single_nal_mode_reg;
                endcase
            end
        end
    end

    assign done         = done_reg;
    assign out_byte     = byte_reg;
    assign out_valid    = valid_reg;
    assign out_last     = last_reg;
    assign delta_action = dact_reg;
    assign overflow     = ovf_reg;

    a_valid_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> done)
        else $error("data flagged valid outside a result beat");
    a_rp_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (rp_reg < fill_reg))
        else $error("read pointer outside a ready unit");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= a2l_pkg::MAX_UNIT_BYTES)
        else $error("fill count beyond capacity");
    a_pull_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PULL) |=> (done && out_valid))
        else $error("pull read did not produce a beat");
endmodule
`default_nettype wire

// ===== tb/sv/annexb_to_length_prefixed_nal_tb.sv =====
// Self-checking testbench for the Annex B to length-prefixed NAL converter.
`default_nettype none
module annexb_to_length_prefixed_nal_tb;
    localparam int STORE_BYTES = 65536;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic       req;
        logic [7:0] data;
        logic       eou;
    } nal_req_t;

    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [1:0] action;
        logic       ovf;
    } nal_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        req_type = a2l_pkg::REQ_PUSH;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_unit = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = a2l_pkg::CFG_SINGLE_NAL;
    logic [15:0] cfg_data = 16'h0000;
    logic        busy, cfg_ready, done, out_valid, out_last, overflow;
    logic [7:0]  out_byte;
    logic [1:0]  delta_action;

    annexb_to_length_prefixed_nal dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .data_byte(data_byte), .end_of_unit(end_of_unit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .out_byte(out_byte), .out_valid(out_valid),
        .out_last(out_last), .delta_action(delta_action), .overflow(overflow)
    );

    always #6 clk = ~clk;

    // Predictor state, kept apart from the block.
    logic [7:0]  unit_mem [STORE_BYTES];
    int unsigned unit_fill, unit_rdptr;
    bit          unit_armed;
    logic [1:0]  unit_delta;
    bit          mode_single;
    int unsigned cfg_pps_off, cfg_psets_end;

    nal_req_t  pending_reqs [$];
    nal_beat_t expected_beats [$];
    int        mismatches = 0;
    int        beats_seen = 0;
    int        units_converted = 0;
    int        idle_pct = 30;
    int        cycles = 0;

    function automatic logic [7:0] unit_rd(int unsigned idx);
        return (idx < unit_fill) ? unit_mem[idx] : 8'h00;
    endfunction

    function automatic bit at_start_code(int unsigned p);
        return unit_rd(p) == 8'h00 && unit_rd(p + 1) == 8'h00 &&
               unit_rd(p + 2) == 8'h00 && unit_rd(p + 3) == 8'h01;
    endfunction

    function automatic void write_length(int unsigned mark, logic [31:0] len);
        for (int unsigned k = 1; k <= a2l_pkg::LENGTH_BYTES; k++)
        begin
            if (mark >= k && mark - k < unit_fill)
                unit_mem[mark - k] = len[7:0];
            len = len >> 8;
        end
    endfunction

    function automatic void convert_stored_unit();
        int unsigned n, mark, first;
        logic [1:0]  act;
        logic [4:0]  nal_kind;
        logic [7:0]  hdr_byte, pps_byte;
        bit          found;
        n = unit_fill;
        mark = 0;
        first = 0;
        act = a2l_pkg::ACT_LEAVE;
        nal_kind = 5'd0;
        found = 0;
        for (int unsigned i = 0; i + 4 < n; i++)
        begin
            if (at_start_code(i))
            begin
                hdr_byte = unit_rd(i + 4);
                if (mode_single)
                begin
                    pps_byte = unit_rd(i + cfg_pps_off);
                    if (hdr_byte[4:0] == a2l_pkg::NAL_SPS &&
                        pps_byte[4:0] == a2l_pkg::NAL_PPS)
                    begin
                        first = i + cfg_psets_end;
                        mark = first + a2l_pkg::LENGTH_BYTES;
                        act = a2l_pkg::ACT_CLEAR;
                    end
                    else
                    begin
                        mark = i + a2l_pkg::LENGTH_BYTES;
                        act = a2l_pkg::ACT_SET;
                    end
                    found = 1;
                    break;
                end
                if (found)
                begin
                    if (nal_kind == a2l_pkg::NAL_SPS || nal_kind == a2l_pkg::NAL_PPS)
                        first = i;
                    else
                        write_length(mark, i - mark);
                end
                mark = i + a2l_pkg::LENGTH_BYTES;
                nal_kind = hdr_byte[4:0];
                found = 1;
            end
        end
        if (found)
            write_length(mark, n - mark);
        unit_delta = act;
        units_converted++;
        if (first < n)
        begin
            unit_rdptr = first;
            unit_armed = 1;
        end
        else
        begin
            unit_fill = 0;
            unit_rdptr = 0;
            unit_armed = 0;
        end
    endfunction

    function automatic nal_beat_t predict_beat(nal_req_t r);
        nal_beat_t b;
        b = '{data: 8'h00, valid: 1'b0, last: 1'b0, action: a2l_pkg::ACT_LEAVE, ovf: 1'b0};
        if (r.req == a2l_pkg::REQ_PUSH)
        begin
            if (unit_armed)
            begin
                b.ovf = 1'b1;
                return b;
            end
            if (unit_fill < STORE_BYTES)
            begin
                unit_mem[unit_fill] = r.data;
                unit_fill++;
            end
            else
                b.ovf = 1'b1;
            if (r.eou)
            begin
                convert_stored_unit();
                b.action = unit_delta;
            end
        end
        else if (unit_armed && unit_rdptr < unit_fill)
        begin
            b.data = unit_mem[unit_rdptr];
            b.valid = 1'b1;
            b.action = unit_delta;
            unit_rdptr++;
            if (unit_rdptr >= unit_fill)
            begin
                b.last = 1'b1;
                unit_fill = 0;
                unit_rdptr = 0;
                unit_armed = 0;
            end
        end
        return b;
    endfunction

    // Request driver: a beat is taken on start high with busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                expected_beats.push_back(predict_beat('{req_type, data_byte, end_of_unit}));
            if (!start || !busy)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nal_req_t r;
                    r = pending_reqs.pop_front();
                    req_type <= r.req;
                    data_byte <= r.data;
                    end_of_unit <= r.eou;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing expected, byte %02h", out_byte);
            end
            else
            begin
                nal_beat_t e;
                e = expected_beats.pop_front();
                if (e.data !== out_byte || e.valid !== out_valid || e.last !== out_last ||
                    e.action !== delta_action || e.ovf !== overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: beat %0d exp byte=%02h v=%b l=%b d=%0d o=%b",
                                  " got byte=%02h v=%b l=%b d=%0d o=%b"},
                                 beats_seen, e.data, e.valid, e.last, e.action, e.ovf,
                                 out_byte, out_valid, out_last, delta_action, overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL annexb_to_length_prefixed_nal");
            $finish;
        end
    end

    task automatic queue_req(logic req, logic [7:0] d, logic eou);
        pending_reqs.push_back('{req, d, eou});
    endtask

    task automatic queue_unit(ref logic [7:0] bytes [$], input int extra_pulls);
        for (int i = 0; i < bytes.size(); i++)
        begin
            if ($urandom_range(29) == 0)
                queue_req(a2l_pkg::REQ_PULL, 8'($urandom), 1'($urandom));
            queue_req(a2l_pkg::REQ_PUSH, bytes[i], i == bytes.size() - 1);
        end
        if ($urandom_range(9) == 0)
            queue_req(a2l_pkg::REQ_PUSH, 8'($urandom), 1'($urandom));
        repeat (bytes.size() + extra_pulls)
            queue_req(a2l_pkg::REQ_PULL, 8'($urandom), 1'($urandom));
    endtask

    task automatic add_start_code(ref logic [7:0] u [$], input logic [4:0] kind);
        u.push_back(8'h00);
        u.push_back(8'h00);
        u.push_back(8'h00);
        u.push_back(8'h01);
        u.push_back({3'($urandom), kind});
    endtask

    // A random unit: either SPS + PPS + slice at fixed offsets, or a random NAL mix.
    task automatic queue_random_unit(bit key_frame);
        logic [7:0] u [$];
        logic [4:0] kinds [5];
        int pulls;
        kinds = '{5'd1, 5'd5, a2l_pkg::NAL_SPS, a2l_pkg::NAL_PPS, 5'($urandom)};
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) u.push_back(8'($urandom_range(1, 255)));
        if (key_frame)
        begin
            add_start_code(u, a2l_pkg::NAL_SPS);
            repeat (3) u.push_back(8'($urandom));
            add_start_code(u, a2l_pkg::NAL_PPS);
            repeat (3) u.push_back(8'($urandom));
            add_start_code(u, 5'd5);
            repeat ($urandom_range(0, 8)) u.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                add_start_code(u, kinds[$urandom_range(4)]);
                repeat ($urandom_range(0, 10)) u.push_back(8'($urandom));
            end
            if (u.size() == 0)
                repeat ($urandom_range(1, 6)) u.push_back(8'($urandom));
        end
        pulls = $urandom_range(0, 2);
        if ($urandom_range(14) == 0)
            pulls = -(u.size() / 2);
        queue_unit(u, pulls);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            a2l_pkg::CFG_SINGLE_NAL: mode_single = value[0];
            a2l_pkg::CFG_PPS_OFFSET: cfg_pps_off = value;
            a2l_pkg::CFG_PSETS_END:  cfg_psets_end = value;
            default: ;
        endcase
    endtask

    task automatic set_config(bit single, logic [15:0] pps_off, logic [15:0] psets_end);
        wait_drained();
        write_reg(a2l_pkg::CFG_SINGLE_NAL, {15'd0, single});
        write_reg(a2l_pkg::CFG_PPS_OFFSET, pps_off);
        write_reg(a2l_pkg::CFG_PSETS_END, psets_end);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int items, bit keys);
        int target;
        target = pending_reqs.size() + items;
        while (pending_reqs.size() < target)
            queue_random_unit(keys && $urandom_range(1) == 1);
    endtask

    initial
    begin
        logic [7:0] u [$];
        unit_fill = 0;
        unit_rdptr = 0;
        unit_armed = 0;
        unit_delta = a2l_pkg::ACT_LEAVE;
        mode_single = 0;
        cfg_pps_off = 0;
        cfg_psets_end = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pull, one NAL, a unit with no start code, push while armed.
        queue_req(a2l_pkg::REQ_PULL, 8'hff, 1'b1);
        u = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hff, 8'h00};
        queue_unit(u, 1);
        u = '{8'hff, 8'h00, 8'h80};
        for (int i = 0; i < 3; i++)
            queue_req(a2l_pkg::REQ_PUSH, u[i], i == 2);
        queue_req(a2l_pkg::REQ_PUSH, 8'h5a, 1'b1);
        repeat (4) queue_req(a2l_pkg::REQ_PULL, 8'h00, 1'b0);
        set_config(1'b1, 16'd12, 16'd16);
        queue_random_unit(1'b1);
        queue_random_unit(1'b0);

        // Random phases across settings, one of them with no idling.
        set_config(1'b0, 16'($urandom), 16'($urandom));
        run_random(260, 1'b1);
        set_config(1'b1, 16'd12, 16'd16);
        idle_pct = 0;
        run_random(260, 1'b1);
        set_config(1'b1, 16'hffff, 16'hffff);
        idle_pct = 30;
        run_random(130, 1'b1);
        set_config(1'b1, 16'd0, 16'd0);
        run_random(130, 1'b1);
        set_config(1'b1, 16'd4, 16'($urandom_range(0, 40)));
        run_random(130, 1'b1);

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Checked %0d result beats over %0d converted units.", beats_seen, units_converted);
        $display("Runs covered both NAL modes, offset extremes, pushes into a held unit and idle pulls.");
        if (mismatches == 0)
            $display("PASS annexb_to_length_prefixed_nal");
        else
            $display("FAIL annexb_to_length_prefixed_nal");
        $finish;
    end
endmodule
`default_nettype wire
